>>> hdl/sfwc_pkg.sv
// ----------------------------------------------------------------------------
// sfwc_pkg
// Shared types and codes for the serial flash sector write-back cache.
// ----------------------------------------------------------------------------
`default_nettype none
package sfwc_pkg;

  localparam logic [2:0] OP_WR_REQ  = 3'd0;
  localparam logic [2:0] OP_WR_DATA = 3'd1;
  localparam logic [2:0] OP_RD_REQ  = 3'd2;
  localparam logic [2:0] OP_TICK    = 3'd3;
  localparam logic [2:0] OP_SPI_RX  = 3'd4;

  localparam logic [1:0] KIND_SPI    = 2'd0;
  localparam logic [1:0] KIND_RDBYTE = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] CMD_ERASE = 8'h20;
  localparam logic [7:0] CMD_RDSR  = 8'h05;
  localparam logic [7:0] CMD_PROG  = 8'h02;
  localparam logic [7:0] CMD_FREAD = 8'h0B;

  localparam logic [4:0] AGE_MAX = 5'd31;

  // Front-to-back queue entry: the accepted input item.
  typedef struct packed {
    logic [2:0]  op;
    logic [14:0] lba;
    logic [7:0]  data;
  } item_t;

  // One result word.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       frame_last;
    logic [7:0] read_byte;
    logic       led;
    logic       last_of_run;
  } res_t;

endpackage
`default_nettype wire

>>> hdl/sfwc_if.sv
// ----------------------------------------------------------------------------
// sfwc_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
`default_nettype none
interface sfwc_if #(
  parameter int W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hdl/sfwc_front.sv
// ----------------------------------------------------------------------------
// sfwc_front
// Input queue: accepts items and holds them for the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module sfwc_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire sfwc_pkg::item_t in_item,
  output logic                 q_valid,
  input  wire logic            q_pop,
  output sfwc_pkg::item_t      q_item
);
  sfwc_pkg::item_t slot [2];
  logic [1:0] count;
  logic       wp, rp;
  logic       push;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rp];

  // Store on push.
  always_ff @(posedge clk) begin
    if (push) slot[wp] <= in_item;
  end

  // Advance pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wp    <= 1'b0;
      rp    <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop && q_valid) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, q_pop && q_valid};
    end
  end
endmodule
`default_nettype wire

>>> hdl/sfwc_back.sv
// ----------------------------------------------------------------------------
// sfwc_back
// Sequencer: carries out one item at a time, emits up to three results
// through a two-entry output skid queue.
// ----------------------------------------------------------------------------
`default_nettype none
module sfwc_back #(
  parameter int SECTOR_BYTES    = 4096,
  parameter int BLOCK_BYTES     = 512,
  parameter int PAGE_BYTES      = 256,
  parameter int FLASH_ADDR_BITS = 24
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [4:0]      cfg_data,
  input  wire logic            q_valid,
  output logic                 q_pop,
  input  wire sfwc_pkg::item_t q_item,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output sfwc_pkg::res_t       out_res
);
  localparam int SB  = $clog2(SECTOR_BYTES);
  localparam int BB  = $clog2(BLOCK_BYTES);
  localparam int PB  = $clog2(PAGE_BYTES);
  localparam int NPG = SECTOR_BYTES / PAGE_BYTES;
  localparam int PIB = (NPG > 1) ? $clog2(NPG) : 1;
  localparam int HSB = (FLASH_ADDR_BITS > SB) ? FLASH_ADDR_BITS - SB : 1;
  localparam int CB  = SB + 2;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_WB_WREN = 9'b000000010,
    S_WB_ERASE= 9'b000000100,
    S_WB_POLL = 9'b000001000,
    S_PG_WREN = 9'b000010000,
    S_PG_PROG = 9'b000100000,
    S_PG_POLL = 9'b001000000,
    S_READ    = 9'b010000000,
    S_DATA    = 9'b100000000
  } seq_t;

  typedef enum logic [2:0] {
    J_TICK  = 3'b001,
    J_WRITE = 3'b010,
    J_READ  = 3'b100
  } job_t;

  typedef enum logic [1:0] {
    P_DECIDE = 2'b01,
    P_EMIT   = 2'b10
  } phase_t;

  // Sector memory.
  logic [7:0]    mem [SECTOR_BYTES];
  logic [7:0]    mem_q;
  logic          mem_we;
  logic [SB-1:0] mem_wa, mem_ra;
  logic [7:0]    mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[mem_ra];
  end

  // Architectural state.
  seq_t             state;
  job_t             job;
  phase_t           phase;
  logic [HSB-1:0]   held_sector;
  logic             cache_valid;
  logic [4:0]       age_count, age_limit;
  logic [PIB-1:0]   page_index;
  logic [CB-1:0]    byte_count;
  logic [14:0]      pending_block;
  logic             led_state;

  // Pending results for the current item.
  sfwc_pkg::res_t   pend [3];
  logic [1:0]       pend_n, pend_i;

  // Output skid queue.
  sfwc_pkg::res_t   oq [2];
  logic [1:0]       oq_n;
  logic             oq_wp, oq_rp;
  logic             oq_push, oq_pop;

  assign out_valid = (oq_n != 2'd0);
  assign out_res   = oq[oq_rp];
  assign oq_pop    = out_valid && out_ready;
  assign oq_push   = (phase == P_EMIT) && (pend_i != pend_n) &&
                     ((oq_n != 2'd2) || oq_pop);

  // Address helpers.
  function automatic logic [FLASH_ADDR_BITS-1:0] faddr(input logic [14:0] l);
    logic [FLASH_ADDR_BITS+14:0] w;
    w = {{(FLASH_ADDR_BITS){1'b0}}, l} << BB;
    return w[FLASH_ADDR_BITS-1:0];
  endfunction

  logic [FLASH_ADDR_BITS-1:0] pend_addr, held_base, frm_addr;
  logic [HSB-1:0]             pend_sec, item_sec;
  logic [CB-1:0]              frm_len;
  logic [31:0]                held_wide;

  always_comb begin
    pend_addr = faddr(pending_block);
    pend_sec  = HSB'(pend_addr >> SB);
    item_sec  = HSB'(faddr(q_item.lba) >> SB);
    held_wide = 32'(held_sector) << SB;
    held_base = held_wide[FLASH_ADDR_BITS-1:0];
    unique case (state)
      S_PG_PROG: frm_addr = held_base + FLASH_ADDR_BITS'(
                   {{(32-PIB){1'b0}}, page_index} << PB);
      S_READ:    frm_addr = (job == J_WRITE) ?
                   (pend_addr & ~FLASH_ADDR_BITS'(SECTOR_BYTES - 1)) : pend_addr;
      default:   frm_addr = held_base;
    endcase
    unique case (state)
      S_WB_ERASE:           frm_len = CB'(4);
      S_WB_POLL, S_PG_POLL: frm_len = CB'(2);
      S_PG_PROG:            frm_len = CB'(4 + PAGE_BYTES);
      S_READ:               frm_len = (job == J_WRITE) ? CB'(5 + SECTOR_BYTES)
                                                       : CB'(5 + BLOCK_BYTES);
      default:              frm_len = CB'(1);
    endcase
  end

  // SPI byte for the current state and position; mem_q holds buffer data.
  function automatic sfwc_pkg::res_t mk(input logic [1:0] k, input logic [7:0] tx,
                                        input logic fl, input logic [7:0] rb,
                                        input logic ld);
    sfwc_pkg::res_t r;
    r.kind = k; r.tx_byte = tx; r.frame_last = fl; r.read_byte = rb;
    r.led = ld; r.last_of_run = 1'b0;
    return r;
  endfunction

  logic [7:0] tx_now;
  logic [31:0] fa32;
  always_comb begin
    fa32 = 32'(frm_addr);
    tx_now = 8'h00;
    if (byte_count >= CB'(1) && byte_count <= CB'(3) &&
        (state == S_WB_ERASE || state == S_PG_PROG || state == S_READ)) begin
      unique case (byte_count[1:0])
        2'd1:    tx_now = fa32[23:16];
        2'd2:    tx_now = fa32[15:8];
        default: tx_now = fa32[7:0];
      endcase
    end else begin
      unique case (state)
        S_WB_WREN, S_PG_WREN: tx_now = sfwc_pkg::CMD_WREN;
        S_WB_ERASE:           tx_now = sfwc_pkg::CMD_ERASE;
        S_WB_POLL, S_PG_POLL: tx_now = (byte_count == '0) ? sfwc_pkg::CMD_RDSR : 8'h00;
        S_PG_PROG:            tx_now = (byte_count == '0) ? sfwc_pkg::CMD_PROG : mem_q;
        S_READ:               tx_now = (byte_count == '0) ? sfwc_pkg::CMD_FREAD : 8'h00;
        default:              tx_now = 8'h00;
      endcase
    end
  end

  // Decide step: compute next state and up to two leading results; the SPI
  // byte of a new frame is appended in the emit step once memory data lands.
  seq_t           state_next;
  job_t           job_next;
  logic [HSB-1:0] held_next;
  logic           valid_next, led_next, emit_spi, pop;
  logic [4:0]     age_next;
  logic [PIB-1:0] page_next;
  logic [CB-1:0]  cnt_next, p1, k;
  logic [14:0]    pblk_next;
  sfwc_pkg::res_t lead [2];
  logic [1:0]     lead_n;
  logic [SB-1:0]  wr_idx;

  always_comb begin
    state_next = state; job_next = job; held_next = held_sector;
    valid_next = cache_valid; led_next = led_state; age_next = age_count;
    page_next = page_index; cnt_next = byte_count; pblk_next = pending_block;
    emit_spi = 1'b0; lead_n = 2'd0;
    lead[0] = mk(sfwc_pkg::KIND_REJECT, 8'h00, 1'b0, 8'h00, led_state);
    lead[1] = lead[0];
    mem_we = 1'b0; mem_wa = '0; mem_wd = q_item.data;
    p1 = byte_count + CB'(1);
    k  = byte_count - CB'(5);
    wr_idx = SB'(pend_addr) + SB'(byte_count);
    unique case (state)
      S_IDLE: begin
        case (q_item.op)
          sfwc_pkg::OP_WR_REQ: begin
            pblk_next = q_item.lba; job_next = J_WRITE;
            if (cache_valid && held_sector == item_sec) begin
              cnt_next = '0; state_next = S_DATA;
            end else if (cache_valid) begin
              state_next = S_WB_WREN; cnt_next = '0; emit_spi = 1'b1;
            end else begin
              led_next = 1'b1; state_next = S_READ; cnt_next = '0; emit_spi = 1'b1;
            end
          end
          sfwc_pkg::OP_RD_REQ: begin
            pblk_next = q_item.lba; job_next = J_READ; cnt_next = '0; emit_spi = 1'b1;
            state_next = cache_valid ? S_WB_WREN : S_READ;
          end
          sfwc_pkg::OP_TICK: begin
            age_next = (age_count < sfwc_pkg::AGE_MAX) ? age_count + 5'd1 : age_count;
            if (cache_valid && age_next > age_limit) begin
              job_next = J_TICK; state_next = S_WB_WREN; cnt_next = '0; emit_spi = 1'b1;
            end
          end
          default: lead_n = 2'd1;
        endcase
      end
      S_DATA: begin
        if (q_item.op == sfwc_pkg::OP_WR_DATA) begin
          if ({1'b0, wr_idx} == (CB-1)'(SB'(pend_addr)) + (CB-1)'(byte_count)) begin
            mem_we = 1'b1;
          end
          mem_wa = wr_idx;
          cnt_next = p1;
          if (p1 >= CB'(BLOCK_BYTES)) begin
            cnt_next = '0; age_next = '0; state_next = S_IDLE; lead_n = 2'd1;
            lead[0] = mk(sfwc_pkg::KIND_DONE, 8'h00, 1'b0, 8'h00, led_state);
          end
        end else begin
          lead_n = 2'd1;
        end
      end
      default: begin
        if (q_item.op == sfwc_pkg::OP_SPI_RX) begin
          if (state == S_READ && byte_count >= CB'(5)) begin
            if (job == J_WRITE) begin
              mem_we = (k < CB'(SECTOR_BYTES)); mem_wa = SB'(k);
            end else begin
              lead_n = 2'd1;
              lead[0] = mk(sfwc_pkg::KIND_RDBYTE, 8'h00, 1'b0, q_item.data, led_state);
            end
          end
          if (p1 < frm_len) begin
            cnt_next = p1; emit_spi = 1'b1;
          end else begin
            cnt_next = '0; emit_spi = 1'b1;
            unique case (state)
              S_WB_WREN:  state_next = S_WB_ERASE;
              S_WB_ERASE: state_next = S_WB_POLL;
              S_WB_POLL: begin
                if (!q_item.data[0]) begin
                  page_next = '0; state_next = S_PG_WREN;
                end
              end
              S_PG_WREN:  state_next = S_PG_PROG;
              S_PG_PROG:  state_next = S_PG_POLL;
              S_PG_POLL: begin
                if (!q_item.data[0]) begin
                  if (32'(page_index) + 1 < NPG) begin
                    page_next = page_index + PIB'(1); state_next = S_PG_WREN;
                  end else begin
                    valid_next = 1'b0; led_next = 1'b0; page_next = '0;
                    if (job == J_TICK) begin
                      state_next = S_IDLE; emit_spi = 1'b0;
                      lead[lead_n[0]] = mk(sfwc_pkg::KIND_DONE, 8'h00, 1'b0,
                                           8'h00, 1'b0);
                      lead_n = lead_n + 2'd1;
                    end else begin
                      state_next = S_READ;
                      if (job == J_WRITE) led_next = 1'b1;
                    end
                  end
                end
              end
              default: begin
                emit_spi = 1'b0;
                if (job == J_WRITE) begin
                  held_next = pend_sec; valid_next = 1'b1; state_next = S_DATA;
                end else begin
                  state_next = S_IDLE;
                  lead[lead_n[0]] = mk(sfwc_pkg::KIND_DONE, 8'h00, 1'b0,
                                       8'h00, led_state);
                  lead_n = lead_n + 2'd1;
                end
              end
            endcase
          end
        end else begin
          lead_n = 2'd1;
        end
      end
    endcase
    // Write the buffer only for the word taken this cycle.
    mem_we = mem_we && pop;
  end

  // Buffer read address for the page byte of the next emitted SPI word;
  // hold it while that word waits in the emit step.
  logic [31:0] rd_w;
  always_comb begin
    if (phase == P_EMIT) rd_w = (32'(page_index) << PB) + 32'(byte_count) - 32'd4;
    else rd_w = (32'(page_next) << PB) + 32'(cnt_next) - 32'd4;
    mem_ra = SB'(rd_w);
  end

  assign pop = (phase == P_DECIDE) && q_valid;
  assign q_pop = pop;

  // Count of leading results stored; SPI word follows them.
  logic [1:0]     lead_fill_n;
  logic           spi_pending;
  sfwc_pkg::res_t spi_res, cur;
  always_ff @(posedge clk) begin
    if (rst) begin
      lead_fill_n <= '0; spi_pending <= 1'b0;
    end else if (pop) begin
      lead_fill_n <= lead_n; spi_pending <= emit_spi;
    end
  end
  assign spi_res = mk(sfwc_pkg::KIND_SPI, tx_now, (p1 >= frm_len), 8'h00, led_state);

  always_comb begin
    cur = (spi_pending && pend_i == lead_fill_n) ? spi_res : pend[pend_i];
    cur.last_of_run = (pend_i + 2'd1 == pend_n);
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; job <= J_TICK; phase <= P_DECIDE;
      held_sector <= '0; cache_valid <= 1'b0; age_count <= '0;
      page_index <= '0; byte_count <= '0; pending_block <= '0;
      led_state <= 1'b0; pend_n <= '0; pend_i <= '0;
    end else begin
      if (pop) begin
        state <= state_next; job <= job_next; held_sector <= held_next;
        cache_valid <= valid_next; led_state <= led_next; age_count <= age_next;
        page_index <= page_next; byte_count <= cnt_next; pending_block <= pblk_next;
        pend_n <= lead_n + {1'b0, emit_spi};
        pend_i <= '0;
        phase  <= P_EMIT;
        pend[0] <= lead[0];
        pend[1] <= lead[1];
      end else if (phase == P_EMIT) begin
        // Fill in the SPI word now that the buffer data is registered.
        if (pend_i == '0 && pend_n != lead_fill_n) pend[lead_fill_n] <= spi_res;
        if (oq_push) pend_i <= pend_i + 2'd1;
        if ((pend_i == pend_n) || (oq_push && pend_i + 2'd1 == pend_n)) phase <= P_DECIDE;
      end
    end
  end

  // Output queue.
  always_ff @(posedge clk) begin
    if (oq_push) oq[oq_wp] <= cur;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      oq_n <= '0; oq_wp <= 1'b0; oq_rp <= 1'b0;
    end else begin
      if (oq_push) oq_wp <= ~oq_wp;
      if (oq_pop) oq_rp <= ~oq_rp;
      oq_n <= oq_n + {1'b0, oq_push} - {1'b0, oq_pop};
    end
  end

  // Configuration.
  always_ff @(posedge clk) begin
    if (rst) age_limit <= 5'd15;
    else if (cfg_we) age_limit <= cfg_data;
  end
endmodule
`default_nettype wire

>>> hdl/spi_flash_sector_writeback_cache_core.sv
// ----------------------------------------------------------------------------
// spi_flash_sector_writeback_cache_core
// One-sector write-back cache in front of a serial NOR flash.
// ----------------------------------------------------------------------------
//   channel   dir   payload
//   in_ch     in    op[2:0] lba[14:0] data[7:0]
//   out_ch    out   kind tx_byte frame_last read_byte led last_of_run
//   cfg       in    cfg_we, cfg_data[4:0] (age_limit)
// An item passes the two sequencer steps (decide, then emit with the
// registered sector-buffer read); emit hands each result to the output queue.
// A two-entry input queue and a two-entry output queue decouple the sides.
// Reset clears control state; the sector buffer is unset until filled.
`default_nettype none
module spi_flash_sector_writeback_cache_core #(
  parameter int SECTOR_BYTES    = 4096,
  parameter int BLOCK_BYTES     = 512,
  parameter int PAGE_BYTES      = 256,
  parameter int FLASH_ADDR_BITS = 24
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_we,
  input  wire logic [4:0] cfg_data,
  sfwc_if.sink       in_ch,
  sfwc_if.source     out_ch
);
  logic            q_valid, q_pop;
  sfwc_pkg::item_t q_item;
  sfwc_pkg::res_t  res;

  sfwc_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_item(sfwc_pkg::item_t'(in_ch.payload)),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  sfwc_back #(
    .SECTOR_BYTES(SECTOR_BYTES), .BLOCK_BYTES(BLOCK_BYTES),
    .PAGE_BYTES(PAGE_BYTES), .FLASH_ADDR_BITS(FLASH_ADDR_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(res)
  );

  assign out_ch.payload = res;
endmodule
`default_nettype wire
